@@ design/ipd_pkg.sv @@
// Shared types, constants and helper functions for the interleaved packet deframer.
package ipd_pkg;

   localparam int MAX_STREAMS = 16;
   localparam int TABLE_DEPTH = 4096;
   localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
   localparam int LEN_W       = TABLE_AW + 1;
   localparam int POS_W       = TABLE_AW;
   localparam int SKIP_BYTES  = 8;
   localparam int SKIP_W      = $clog2(SKIP_BYTES);
   localparam int STREAM_W    = 4;
   localparam int CSR_W       = 5;
   localparam int PROD_W      = 2 * CSR_W;

   localparam logic [CSR_W-1:0] STREAM_COUNT_RESET = CSR_W'(2);

   typedef enum logic [2:0] {
      ST_COUNT,
      ST_SKIP,
      ST_SIZES,
      ST_READ,
      ST_CHECK,
      ST_PAYLOAD
   } state_type;

   typedef struct packed {
      logic resync;
      logic load_count;
      logic skip_step;
      logic enter_sizes;
      logic size_byte;
      logic start_settle;
      logic read_issue;
      logic advance;
      logic load_bytes;
      logic emit_error;
      logic emit_byte;
   } dp_cmd_type;

   typedef struct packed {
      logic byte_zero;
      logic skip_last;
      logic word_last;
      logic table_done;
      logic pos_in_table;
      logic read_zero;
      logic bytes_last;
      logic next_stream_zero;
      logic rsp_hold;
   } dp_status_type;

   function automatic logic [CSR_W-1:0] eff_streams(input logic [CSR_W-1:0] n);
      logic [CSR_W-1:0] r;
      r = n;
      if (n == '0) begin
         r = CSR_W'(1);
      end
      if (n > CSR_W'(MAX_STREAMS)) begin
         r = CSR_W'(MAX_STREAMS);
      end
      return r;
   endfunction

   // a mod n for a up to MAX_STREAMS and n from 1 to MAX_STREAMS
   function automatic logic [STREAM_W-1:0] stream_wrap(input logic [CSR_W-1:0] a,
                                                       input logic [CSR_W-1:0] n);
      logic [PROD_W-1:0] prod;
      logic [PROD_W-1:0] a_ext;
      logic [PROD_W-1:0] r;
      a_ext = PROD_W'(a);
      r     = a_ext;
      for (int q = 1; q <= MAX_STREAMS; q++) begin
         prod = PROD_W'(q) * PROD_W'(n);
         if (prod <= a_ext) begin
            r = a_ext - prod;
         end
      end
      return r[STREAM_W-1:0];
   endfunction

endpackage

@@ design/interleaved_packet_deframer_top.sv @@
// Top level of the interleaved packet deframer: controller plus datapath.
//
//   channel   dir   handshake               word
//   req_      in    req_valid / req_ready   action, data_byte
//   rsp_      out   rsp_valid / rsp_ready   status, payload_byte, stream_id,
//                                           packet_last, video_frame
//   csr_      in    csr_wr_en               stream_count
//
// One word per cycle in the count, skip, size and payload phases unless stalled.
// Each table entry visited after the size table or a packet end passes a memory
// read state and a size check state with req_ready low; each zero-size packet
// passed repeats both, and a position past the table takes the read state only.
// Reset is synchronous: stream count returns to 2, parse state and frame counter
// clear; size table contents stay undefined until written, no clearing pass.
// req_ready drops while a result waits in the output register and rsp_ready is low.
module interleaved_packet_deframer_top import ipd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_action,
   input  logic [7:0]          req_data_byte,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_status,
   output logic [7:0]          rsp_payload_byte,
   output logic [STREAM_W-1:0] rsp_stream_id,
   output logic                rsp_packet_last,
   output logic [31:0]         rsp_video_frame,
   input  logic                csr_wr_en,
   input  logic [CSR_W-1:0]    csr_wr_data
);

   dp_cmd_type    cmd;
   dp_status_type stat;

   ipd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .stat       (stat),
      .cmd        (cmd)
   );

   ipd_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .data_byte        (req_data_byte),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_stream_id    (rsp_stream_id),
      .rsp_packet_last  (rsp_packet_last),
      .rsp_video_frame  (rsp_video_frame)
   );

endmodule

@@ design/ipd_datapath.sv @@
// Datapath of the deframer: parse registers, size table, stream rotation and result register.
module ipd_datapath import ipd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_status_type       stat,
   input  logic [7:0]          data_byte,
   input  logic                csr_wr_en,
   input  logic [CSR_W-1:0]    csr_wr_data,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic                rsp_status,
   output logic [7:0]          rsp_payload_byte,
   output logic [STREAM_W-1:0] rsp_stream_id,
   output logic                rsp_packet_last,
   output logic [31:0]         rsp_video_frame
);

   logic [31:0] size_mem [TABLE_DEPTH];

   logic [CSR_W-1:0]    stream_count_ff, stream_count_in;
   logic [7:0]          audio_ff, audio_in;
   logic [SKIP_W-1:0]   skip_ff, skip_in;
   logic [31:0]         asm_ff, asm_in;
   logic [1:0]          biw_ff, biw_in;
   logic [LEN_W-1:0]    fill_ff, fill_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [STREAM_W-1:0] stream_ff, stream_in;
   logic [31:0]         bytes_ff, bytes_in;
   logic [31:0]         frame_ff, frame_in;
   logic [31:0]         rd_data_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_status_ff, rsp_status_in;
   logic [7:0]          rsp_byte_ff, rsp_byte_in;
   logic [STREAM_W-1:0] rsp_stream_ff, rsp_stream_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [31:0]         rsp_frame_ff, rsp_frame_in;

   logic [CSR_W-1:0]    eff;
   logic [STREAM_W-1:0] eff_m1;
   logic [LEN_W-1:0]    len_prod;
   logic [LEN_W-1:0]    len_calc;
   logic [POS_W-1:0]    pos_next;
   logic                adv;
   logic [STREAM_W-1:0] stream_adv;
   logic [31:0]         asm_new;
   logic [LEN_W-1:0]    fill_next;
   logic                write_en;

   assign eff      = eff_streams(stream_count_ff);
   assign eff_m1   = STREAM_W'(eff - CSR_W'(1));
   assign len_prod = LEN_W'(eff_m1) * LEN_W'(data_byte);
   assign len_calc = (len_prod >= LEN_W'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH)
                                                       : len_prod + LEN_W'(1);

   assign pos_next   = pos_ff + POS_W'(1);
   assign adv        = (pos_next == POS_W'(1)) || (pos_next > POS_W'(audio_ff));
   assign stream_adv = adv ? stream_wrap(CSR_W'(stream_ff) + CSR_W'(1), eff) : stream_ff;

   assign asm_new   = asm_ff | (32'(data_byte) << {biw_ff, 3'b000});
   assign fill_next = fill_ff + LEN_W'(1);
   assign write_en  = cmd.size_byte && (biw_ff == 2'd3) && (fill_ff < LEN_W'(TABLE_DEPTH));

   always_comb begin
      stat.byte_zero        = (data_byte == 8'd0);
      stat.skip_last        = (skip_ff == SKIP_W'(SKIP_BYTES - 1));
      stat.word_last        = (biw_ff == 2'd3);
      stat.table_done       = (fill_next >= len_ff);
      stat.pos_in_table     = (LEN_W'(pos_ff) < len_ff);
      stat.read_zero        = (rd_data_ff == 32'd0);
      stat.bytes_last       = (bytes_ff <= 32'd1);
      stat.next_stream_zero = (stream_adv == '0);
      stat.rsp_hold         = rsp_valid_ff && !rsp_ready;
   end

   always_comb begin
      stream_count_in = csr_wr_en ? csr_wr_data : stream_count_ff;
      audio_in        = audio_ff;
      skip_in         = skip_ff;
      asm_in          = asm_ff;
      biw_in          = biw_ff;
      fill_in         = fill_ff;
      len_in          = len_ff;
      pos_in          = pos_ff;
      stream_in       = stream_ff;
      bytes_in        = bytes_ff;
      frame_in        = frame_ff;

      if (cmd.resync) begin
         stream_in = '0;
         pos_in    = '0;
         skip_in   = '0;
         biw_in    = '0;
         asm_in    = '0;
         bytes_in  = '0;
      end
      if (cmd.load_count) begin
         audio_in  = data_byte;
         len_in    = len_calc;
         fill_in   = '0;
         pos_in    = '0;
         stream_in = '0;
         skip_in   = '0;
      end
      if (cmd.skip_step) begin
         skip_in = skip_ff + SKIP_W'(1);
      end
      if (cmd.enter_sizes) begin
         skip_in = '0;
         biw_in  = '0;
         asm_in  = '0;
      end
      if (cmd.size_byte) begin
         if (biw_ff == 2'd3) begin
            fill_in = fill_next;
            biw_in  = '0;
            asm_in  = '0;
         end else begin
            biw_in = biw_ff + 2'd1;
            asm_in = asm_new;
         end
      end
      if (cmd.start_settle) begin
         pos_in    = '0;
         stream_in = '0;
      end
      if (cmd.advance) begin
         pos_in    = pos_next;
         stream_in = stream_adv;
      end
      if (cmd.load_bytes) begin
         bytes_in = rd_data_ff;
      end
      if (cmd.emit_byte) begin
         if (bytes_ff <= 32'd1) begin
            bytes_in = '0;
            if (stream_ff == '0) begin
               frame_in = frame_ff + 32'd1;
            end
         end else begin
            bytes_in = bytes_ff - 32'd1;
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_stream_in = rsp_stream_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_frame_in  = rsp_frame_ff;
      if (cmd.emit_error) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = 1'b1;
         rsp_byte_in   = '0;
         rsp_stream_in = '0;
         rsp_last_in   = 1'b0;
         rsp_frame_in  = '0;
      end else if (cmd.emit_byte) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = 1'b0;
         rsp_byte_in   = data_byte;
         rsp_stream_in = stream_ff;
         rsp_last_in   = (bytes_ff <= 32'd1);
         rsp_frame_in  = (stream_ff == '0) ? frame_ff : 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stream_count_ff <= STREAM_COUNT_RESET;
         audio_ff        <= '0;
         skip_ff         <= '0;
         asm_ff          <= '0;
         biw_ff          <= '0;
         fill_ff         <= '0;
         len_ff          <= '0;
         pos_ff          <= '0;
         stream_ff       <= '0;
         bytes_ff        <= '0;
         frame_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         stream_count_ff <= stream_count_in;
         audio_ff        <= audio_in;
         skip_ff         <= skip_in;
         asm_ff          <= asm_in;
         biw_ff          <= biw_in;
         fill_ff         <= fill_in;
         len_ff          <= len_in;
         pos_ff          <= pos_in;
         stream_ff       <= stream_in;
         bytes_ff        <= bytes_in;
         frame_ff        <= frame_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_stream_ff <= rsp_stream_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_frame_ff  <= rsp_frame_in;
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         size_mem[fill_ff[TABLE_AW-1:0]] <= asm_new;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_issue) begin
         rd_data_ff <= size_mem[pos_ff];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_payload_byte = rsp_byte_ff;
   assign rsp_stream_id    = rsp_stream_ff;
   assign rsp_packet_last  = rsp_last_ff;
   assign rsp_video_frame  = rsp_frame_ff;

   a_error_word_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff |->
         rsp_byte_ff == 8'd0 && rsp_stream_ff == '0 && !rsp_last_ff && rsp_frame_ff == 32'd0)
      else $error("error word carries nonzero payload fields");

   a_read_in_table: assert property (@(posedge clock) disable iff (reset)
      cmd.read_issue |-> stat.pos_in_table)
      else $error("size table read outside the loaded table");

   a_rsp_hold_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=>
         rsp_valid_ff && $stable(rsp_status_ff) && $stable(rsp_byte_ff) &&
         $stable(rsp_stream_ff) && $stable(rsp_last_ff) && $stable(rsp_frame_ff))
      else $error("stalled output word changed");

endmodule

@@ design/ipd_ctrl.sv @@
// Controller of the deframer: phase state machine issuing datapath commands.
module ipd_ctrl import ipd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_action,
   input  dp_status_type stat,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff != ST_READ) && (state_ff != ST_CHECK) && !stat.rsp_hold;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COUNT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      if (accept && req_action) begin
         cmd.resync = 1'b1;
         state_in   = ST_COUNT;
      end else begin
         unique case (state_ff)
            ST_COUNT: begin
               if (accept) begin
                  if (stat.byte_zero) begin
                     cmd.emit_error = 1'b1;
                  end else begin
                     cmd.load_count = 1'b1;
                     state_in       = ST_SKIP;
                  end
               end
            end
            ST_SKIP: begin
               if (accept) begin
                  if (stat.skip_last) begin
                     cmd.enter_sizes = 1'b1;
                     state_in        = ST_SIZES;
                  end else begin
                     cmd.skip_step = 1'b1;
                  end
               end
            end
            ST_SIZES: begin
               if (accept) begin
                  cmd.size_byte = 1'b1;
                  if (stat.word_last && stat.table_done) begin
                     cmd.start_settle = 1'b1;
                     state_in         = ST_READ;
                  end
               end
            end
            ST_READ: begin
               if (stat.pos_in_table) begin
                  cmd.read_issue = 1'b1;
                  state_in       = ST_CHECK;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = stat.next_stream_zero ? ST_COUNT : ST_READ;
               end
            end
            ST_CHECK: begin
               if (!stat.read_zero) begin
                  cmd.load_bytes = 1'b1;
                  state_in       = ST_PAYLOAD;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = stat.next_stream_zero ? ST_COUNT : ST_READ;
               end
            end
            ST_PAYLOAD: begin
               if (accept) begin
                  cmd.emit_byte = 1'b1;
                  if (stat.bytes_last) begin
                     cmd.advance = 1'b1;
                     state_in    = stat.next_stream_zero ? ST_COUNT : ST_READ;
                  end
               end
            end
            default: begin
               state_in = ST_COUNT;
            end
         endcase
      end
   end

   a_check_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHECK |-> $past(state_ff) == ST_READ)
      else $error("size check without a preceding table read");

   a_payload_entry: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PAYLOAD && $past(state_ff) != ST_PAYLOAD |-> $past(state_ff) == ST_CHECK)
      else $error("payload entered without a nonzero packet size");

   a_emit_not_stalled: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_byte || cmd.emit_error) |-> !stat.rsp_hold)
      else $error("result issued while the output word is stalled");

endmodule

@@ tb/sv/tb_interleaved_packet_deframer_top.sv @@
// Self-checking testbench for the interleaved packet deframer: predicts every result word.
module tb_interleaved_packet_deframer_top import ipd_pkg::*; ();

   localparam logic ACT_BYTE          = 1'b0;
   localparam logic ACT_RESYNC        = 1'b1;
   localparam logic STATUS_DATA       = 1'b0;
   localparam logic STATUS_ZERO_COUNT = 1'b1;
   localparam int   MAX_REPORTS       = 10;
   localparam int   ITEM_TARGET       = 700;
   localparam int   CALM_FROM         = 600;
   localparam int   SETTLE_CYCLES     = 6;
   localparam int   TAIL_CYCLES       = 40;
   localparam int   WATCHDOG_LIMIT    = 80000;

   typedef struct packed {
      logic                status;
      logic [7:0]          payload;
      logic [STREAM_W-1:0] stream;
      logic                last;
      logic [31:0]         frame;
   } deframed_word_type;

   class deframer_board;
      logic [CSR_W-1:0]    stream_cfg;
      state_type           phase;
      logic [7:0]          audio_count;
      logic [2:0]          skip_count;
      logic [31:0]         size_acc;
      logic [1:0]          size_byte;
      logic [31:0]         sizes [TABLE_DEPTH];
      logic [LEN_W-1:0]    fill_count;
      logic [LEN_W-1:0]    table_len;
      logic [LEN_W-1:0]    position;
      logic [STREAM_W-1:0] stream;
      logic [31:0]         remaining;
      logic [31:0]         frame_no;
      deframed_word_type   expected_words [$];
      int unsigned         errors;
      int unsigned         payload_words;
      int unsigned         packet_ends;
      int unsigned         zero_counts;
      int unsigned         resyncs;
      int unsigned         empty_packets;

      function new();
         stream_cfg    = STREAM_COUNT_RESET;
         phase         = ST_COUNT;
         audio_count   = '0;
         skip_count    = '0;
         size_acc      = '0;
         size_byte     = '0;
         fill_count    = '0;
         table_len     = '0;
         position      = '0;
         stream        = '0;
         remaining     = '0;
         frame_no      = '0;
         errors        = 0;
         payload_words = 0;
         packet_ends   = 0;
         zero_counts   = 0;
         resyncs       = 0;
         empty_packets = 0;
      endfunction

      function void set_streams(input logic [CSR_W-1:0] value);
         stream_cfg = value;
      endfunction

      function int unsigned active_streams();
         if (stream_cfg == 0) begin
            return 1;
         end
         if (stream_cfg > MAX_STREAMS) begin
            return MAX_STREAMS;
         end
         return stream_cfg;
      endfunction

      function void next_packet();
         position++;
         if (position == 1 || position > audio_count) begin
            stream = STREAM_W'((int'(stream) + 1) % active_streams());
         end
      endfunction

      // pass empty packets until one with bytes or the end of the frame
      function void load_packet();
         while (1) begin
            if (position < table_len && position < TABLE_DEPTH) begin
               remaining = sizes[position[TABLE_AW-1:0]];
            end else begin
               remaining = '0;
            end
            if (remaining != 0) begin
               phase = ST_PAYLOAD;
               return;
            end
            empty_packets++;
            next_packet();
            if (stream == 0) begin
               phase = ST_COUNT;
               return;
            end
         end
      endfunction

      function void note_word(input logic act, input logic [7:0] b);
         deframed_word_type w;
         int unsigned       len;
         if (act == ACT_RESYNC) begin
            resyncs++;
            phase     = ST_COUNT;
            stream    = '0;
            position  = '0;
            skip_count = '0;
            size_byte = '0;
            size_acc  = '0;
            remaining = '0;
            return;
         end
         case (phase)
            ST_COUNT: begin
               if (b == 0) begin
                  w = '0;
                  w.status = STATUS_ZERO_COUNT;
                  expected_words.push_back(w);
                  zero_counts++;
               end else begin
                  len = (active_streams() - 1) * b + 1;
                  if (len > TABLE_DEPTH) begin
                     len = TABLE_DEPTH;
                  end
                  audio_count = b;
                  table_len   = LEN_W'(len);
                  fill_count  = '0;
                  position    = '0;
                  stream      = '0;
                  skip_count  = '0;
                  phase       = ST_SKIP;
               end
            end
            ST_SKIP: begin
               if (skip_count >= SKIP_BYTES - 1) begin
                  skip_count = '0;
                  size_byte  = '0;
                  size_acc   = '0;
                  phase      = ST_SIZES;
               end else begin
                  skip_count++;
               end
            end
            ST_SIZES: begin
               size_acc |= 32'(b) << (8 * size_byte);
               if (size_byte == 2'd3) begin
                  if (fill_count < TABLE_DEPTH) begin
                     sizes[fill_count[TABLE_AW-1:0]] = size_acc;
                  end
                  fill_count++;
                  size_byte = '0;
                  size_acc  = '0;
                  if (fill_count >= table_len) begin
                     position = '0;
                     stream   = '0;
                     load_packet();
                  end
               end else begin
                  size_byte++;
               end
            end
            default: begin
               w.status  = STATUS_DATA;
               w.payload = b;
               w.stream  = stream;
               w.last    = (remaining <= 1);
               w.frame   = (stream == 0) ? frame_no : 32'd0;
               expected_words.push_back(w);
               payload_words++;
               if (remaining > 0) begin
                  remaining--;
               end
               if (w.last) begin
                  packet_ends++;
                  remaining = '0;
                  if (stream == 0) begin
                     frame_no++;
                  end
                  next_packet();
                  if (stream == 0) begin
                     phase = ST_COUNT;
                  end else begin
                     load_packet();
                  end
               end
            end
         endcase
      endfunction

      function void check_word(input deframed_word_type got);
         deframed_word_type want;
         if (expected_words.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("unexpected word: st=%0d byte=%02h strm=%0d last=%0d frame=%0d",
                        got.status, got.payload, got.stream, got.last, got.frame);
            end
            return;
         end
         want = expected_words.pop_front();
         if (got.status !== want.status || got.payload !== want.payload ||
             got.stream !== want.stream || got.last !== want.last ||
             got.frame !== want.frame) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("mismatch: expected st=%0d byte=%02h strm=%0d last=%0d frame=%0d",
                        want.status, want.payload, want.stream, want.last, want.frame);
               $display("          actual   st=%0d byte=%02h strm=%0d last=%0d frame=%0d",
                        got.status, got.payload, got.stream, got.last, got.frame);
            end
         end
      endfunction
   endclass

   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_ready;
   logic                req_action    = 1'b0;
   logic [7:0]          req_data_byte = '0;
   logic                rsp_valid;
   logic                rsp_ready     = 1'b0;
   logic                rsp_status;
   logic [7:0]          rsp_payload_byte;
   logic [STREAM_W-1:0] rsp_stream_id;
   logic                rsp_packet_last;
   logic [31:0]         rsp_video_frame;
   logic                csr_wr_en     = 1'b0;
   logic [CSR_W-1:0]    csr_wr_data   = '0;

   deframer_board     board;
   deframed_word_type seen_word;
   int                sent        = 0;
   int                configs     = 0;
   int                hold        = 0;
   int                idle_cycles = 0;
   logic              quiet_phase = 1'b0;
   logic              calm        = 1'b0;

   interleaved_packet_deframer_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_stream_id    (rsp_stream_id),
      .rsp_packet_last  (rsp_packet_last),
      .rsp_video_frame  (rsp_video_frame),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_ready <= 1'b1;
         hold      <= 0;
      end else if (hold > 1) begin
         hold <= hold - 1;
      end else if (hold == 1) begin
         hold      <= 0;
         rsp_ready <= 1'b1;
      end else if ($urandom_range(0, 99) < 8) begin
         hold      <= $urandom_range(1, 18);
         rsp_ready <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            seen_word = '{rsp_status, rsp_payload_byte, rsp_stream_id,
                          rsp_packet_last, rsp_video_frame};
            board.check_word(seen_word);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake in %0d cycles, %0d words outstanding",
                     WATCHDOG_LIMIT, board.expected_words.size());
            $display("FAIL");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   task automatic send_word(input logic act, input logic [7:0] b);
      if (!calm && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= act;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
      board.note_word(act, b);
      sent++;
      calm = quiet_phase || (sent >= CALM_FROM);
   endtask

   // hold off until every result is out and the block takes words again, then write the stream count
   task automatic drain_and_configure(input logic [CSR_W-1:0] value);
      req_valid <= 1'b0;
      while (board.expected_words.size() != 0) @(posedge clock);
      do @(posedge clock); while (!req_ready);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.set_streams(value);
      configs++;
   endtask

   task automatic run_directed();
      logic [7:0] skip_pattern [SKIP_BYTES] = '{8'h00, 8'hFF, 8'h55, 8'hAA,
                                               8'h0F, 8'hF0, 8'h80, 8'h7F};
      send_word(ACT_BYTE, 8'h00);
      send_word(ACT_RESYNC, 8'hFF);
      send_word(ACT_BYTE, 8'h01);
      foreach (skip_pattern[i]) send_word(ACT_BYTE, skip_pattern[i]);
      repeat (4) send_word(ACT_BYTE, 8'hFF);
      repeat (4) send_word(ACT_BYTE, 8'h00);
      send_word(ACT_BYTE, 8'h00);
      send_word(ACT_BYTE, 8'hFF);
      send_word(ACT_BYTE, 8'hA5);
      send_word(ACT_RESYNC, 8'h00);
   endtask

   task automatic send_frame();
      int unsigned streams;
      int unsigned amax;
      int unsigned a;
      int unsigned len;
      int          cut;
      int          n;
      int unsigned r;
      logic [31:0] sz;
      bit          big;
      if (board.phase != ST_COUNT) begin
         send_word(ACT_RESYNC, 8'($urandom));
      end
      streams = board.active_streams();
      big     = (streams <= 2) && (sent < 400) && ($urandom_range(0, 49) == 0);
      if (streams == 1) begin
         a = $urandom_range(1, 255);
      end else if (big) begin
         a = $urandom_range(128, 255);
      end else begin
         amax = 12 / (streams - 1);
         if (amax < 1) begin
            amax = 1;
         end
         a = ($urandom_range(0, 9) < 7 && amax > 3) ? $urandom_range(1, 3)
                                                     : $urandom_range(1, amax);
      end
      if ($urandom_range(0, 99) < 5) begin
         send_word(ACT_BYTE, 8'h00);
      end
      send_word(ACT_BYTE, 8'(a));
      repeat (SKIP_BYTES) send_word(ACT_BYTE, 8'($urandom));
      len = (streams - 1) * a + 1;
      repeat (len) begin
         r = $urandom_range(0, 99);
         if (big) begin
            sz = (r < 90) ? 32'd0 : 32'($urandom_range(1, 3));
         end else if (r < 25) begin
            sz = 32'd0;
         end else if (r < 90) begin
            sz = 32'($urandom_range(1, 6));
         end else begin
            sz = 32'($urandom_range(7, 40));
         end
         for (int k = 0; k < 4; k++) begin
            send_word(ACT_BYTE, sz[8*k +: 8]);
         end
      end
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : -1;
      n   = 0;
      while (board.phase == ST_PAYLOAD && (cut < 0 || n < cut)) begin
         send_word(ACT_BYTE, 8'($urandom));
         n++;
      end
   endtask

   task automatic run_phase(input logic [CSR_W-1:0] cfg);
      int frames;
      int n;
      drain_and_configure(cfg);
      quiet_phase = ($urandom_range(0, 3) == 0);
      calm        = quiet_phase || (sent >= CALM_FROM);
      if (board.phase == ST_PAYLOAD) begin
         if ($urandom_range(0, 1) == 0) begin
            send_word(ACT_RESYNC, 8'($urandom));
         end else begin
            n = 0;
            while (board.phase == ST_PAYLOAD && n < 200) begin
               send_word(ACT_BYTE, 8'($urandom));
               n++;
            end
         end
      end
      frames = $urandom_range(1, 4);
      repeat (frames) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) begin
               send_word(($urandom_range(0, 4) == 0) ? ACT_RESYNC : ACT_BYTE,
                         8'($urandom));
            end
         end
         send_frame();
      end
   endtask

   initial begin
      logic [CSR_W-1:0] opening_cfgs [7];
      logic [CSR_W-1:0] cfg;
      int               phase_no;
      int unsigned      r;
      opening_cfgs = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd17, 5'd3, 5'd2};
      board = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      drain_and_configure(5'd2);
      run_directed();
      phase_no = 0;
      while (sent < ITEM_TARGET) begin
         if (phase_no < 7) begin
            cfg = opening_cfgs[phase_no];
         end else begin
            r   = $urandom_range(0, 99);
            cfg = (r < 50) ? CSR_W'($urandom_range(1, 4)) :
                  (r < 80) ? CSR_W'($urandom_range(5, 16)) : CSR_W'($urandom_range(0, 31));
         end
         run_phase(cfg);
         phase_no++;
      end
      req_valid <= 1'b0;
      while (board.expected_words.size() != 0) @(posedge clock);
      do @(posedge clock); while (!req_ready);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d input words, %0d stream-count settings, %0d resyncs",
               sent, configs, board.resyncs);
      $display("checked %0d payload words, %0d packet ends, %0d zero counts, %0d empty packets",
               board.payload_words, board.packet_ends, board.zero_counts,
               board.empty_packets);
      if (board.errors == 0 && board.expected_words.size() == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches, %0d words outstanding", board.errors,
                  board.expected_words.size());
         $display("FAIL");
      end
      $finish;
   end

endmodule
